### hdl/spbq_pkg.sv
// Package: sizes, codes, entry and result types of the booking queues.
package spbq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int SLOT_COUNT    = 20;
    localparam int TYPE_COUNT    = 7;
    localparam int SEQ_BITS      = 10;
    localparam int CLASS_COUNT   = 3;

    localparam int POS_BITS      = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_BITS     = $clog2(CLASS_COUNT * QUEUE_DEPTH);
    localparam int MEM_DEPTH     = CLASS_COUNT * QUEUE_DEPTH;
    localparam int TYPE_IDX_BITS = $clog2(TYPE_COUNT);

    typedef logic [1:0] t_class;

    localparam t_class CLASS_EMERGENCY = 2'd0;
    localparam t_class CLASS_SENIOR    = 2'd1;
    localparam t_class CLASS_NORMAL    = 2'd2;
    localparam t_class CLASS_SPARE     = 2'd3;

    localparam logic [1:0] MODE_BOOK   = 2'd0;
    localparam logic [1:0] MODE_SERVE  = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOTHING   = 3'd1;
    localparam logic [2:0] ST_NO_SLOT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [SEQ_BITS-1:0] seq;
        logic [2:0]          ctype;
        logic [4:0]          slot;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef struct packed {
        logic [2:0]  status;
        t_class      cls;
        logic [9:0]  seq;
        logic [2:0]  ctype;
        logic [4:0]  slot;
        logic        slot_valid;
        logic [2:0]  room;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CK,
        S_SH_RD,
        S_SH_WR,
        S_OUT
    } t_state;

    function automatic logic [ADDR_BITS-1:0] addr_of(t_class cls, logic [POS_BITS-1:0] pos);
        return ADDR_BITS'(cls) * ADDR_BITS'(QUEUE_DEPTH) + ADDR_BITS'(pos);
    endfunction

endpackage

### hdl/spbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/strict_priority_booking_queues.sv
// Top level: three strict-priority booking queues driven by a small sequencer.
// A book (ok or refused) or an empty serve is answered the cycle after accept.
// Serve and cancel walk the class queue on the shared RAM port, a read and a check state
// per entry scanned and a read and a write state per entry shifted, plus a closing state;
// one transaction at a time, the next is accepted the cycle after the result leaves.
// Reset (synchronous, active low) empties the queues, frees every slot and sets each
// class sequence counter to one; the RAM is not cleared.
module strict_priority_booking_queues (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [1:0] i_priority_class,
    input  logic [2:0] i_checkup_type,
    input  logic [9:0] i_cancel_seq,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [1:0] o_served_class,
    output logic [9:0] o_patient_seq,
    output logic [2:0] o_out_type,
    output logic [4:0] o_slot_index,
    output logic       o_slot_valid,
    output logic [2:0] o_room
);
    import spbq_pkg::*;

    // Sequencer and bookkeeping state.
    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_count [CLASS_COUNT];
    logic [CNT_BITS-1:0]   n_count [CLASS_COUNT];
    logic [SEQ_BITS-1:0]   r_seq   [CLASS_COUNT];
    logic [SEQ_BITS-1:0]   n_seq   [CLASS_COUNT];
    logic [SLOT_COUNT-1:0] r_slot_map [TYPE_COUNT];
    logic [SLOT_COUNT-1:0] n_slot_map [TYPE_COUNT];

    // Working registers of the current transaction (payload, no reset).
    t_class                r_cls, n_cls;
    logic [CNT_BITS-1:0]   r_idx, n_idx;
    logic                  r_serve, n_serve;
    logic [SEQ_BITS-1:0]   r_cseq, n_cseq;
    t_entry                r_ent, n_ent;
    t_result               r_res, n_res;

    // Queue RAM port.
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [ADDR_BITS-1:0]  ram_raddr;
    t_entry                ram_wdata;
    t_entry                ram_rdata;

    // Input decode.
    t_class                    in_cls;
    logic [TYPE_IDX_BITS-1:0]  in_type_idx;
    logic [SLOT_COUNT-1:0]     in_row;
    logic                      free_found;
    logic [4:0]                free_slot;
    logic                      serve_any;
    t_class                    serve_cls;
    logic [CNT_BITS-1:0]       idx_inc;
    logic [TYPE_IDX_BITS-1:0]  ent_type_idx;

    spbq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    function automatic t_result make_ok(t_class cls, t_entry e);
        t_result res;
        res.status     = ST_OK;
        res.cls        = cls;
        res.seq        = 10'(e.seq);
        res.ctype      = e.ctype;
        res.slot_valid = (cls != CLASS_EMERGENCY);
        res.slot       = res.slot_valid ? e.slot : 5'd0;
        res.room       = e.ctype + 3'd1;
        return res;
    endfunction

    function automatic t_result make_err(logic [2:0] status);
        t_result res;
        res        = '0;
        res.status = status;
        return res;
    endfunction

    // Class three books and cancels as normal.
    assign in_cls       = (i_priority_class == CLASS_SPARE) ? CLASS_NORMAL : i_priority_class;
    assign in_type_idx  = i_checkup_type[TYPE_IDX_BITS-1:0];
    assign in_row       = r_slot_map[in_type_idx];
    assign idx_inc      = r_idx + CNT_BITS'(1);
    assign ent_type_idx = r_ent.ctype[TYPE_IDX_BITS-1:0];

    // Lowest free slot of the requested type.
    always_comb begin
        free_found = 1'b0;
        free_slot  = 5'd0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!in_row[s]) begin
                free_found = 1'b1;
                free_slot  = 5'(s);
            end
        end
    end

    // Highest-priority non-empty queue.
    always_comb begin
        serve_any = 1'b0;
        serve_cls = CLASS_EMERGENCY;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (r_count[c] != '0) begin
                serve_any = 1'b1;
                serve_cls = 2'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_count[c] <= '0;
                r_seq[c]   <= SEQ_BITS'(1);
            end
            for (int t = 0; t < TYPE_COUNT; t++) begin
                r_slot_map[t] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_seq      <= n_seq;
            r_slot_map <= n_slot_map;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls   <= n_cls;
        r_idx   <= n_idx;
        r_serve <= n_serve;
        r_cseq  <= n_cseq;
        r_ent   <= n_ent;
        r_res   <= n_res;
    end

    always_comb begin
        t_entry book_ent;
        n_state    = r_state;
        n_count    = r_count;
        n_seq      = r_seq;
        n_slot_map = r_slot_map;
        n_cls      = r_cls;
        n_idx      = r_idx;
        n_serve    = r_serve;
        n_cseq     = r_cseq;
        n_ent      = r_ent;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_waddr  = addr_of(r_cls, r_idx[POS_BITS-1:0]);
        ram_raddr  = addr_of(r_cls, r_idx[POS_BITS-1:0]);
        ram_wdata  = r_ent;
        book_ent.seq   = r_seq[in_cls];
        book_ent.ctype = i_checkup_type;
        book_ent.slot  = (in_cls != CLASS_EMERGENCY) ? free_slot : 5'd0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_OUT;
                    n_cseq  = i_cancel_seq;
                    case (i_mode)
                        MODE_BOOK: begin
                            if (32'(i_checkup_type) >= TYPE_COUNT) begin
                                n_res = make_err(ST_NO_SLOT);
                            end else if (in_cls != CLASS_EMERGENCY && !free_found) begin
                                n_res = make_err(ST_NO_SLOT);
                            end else if (32'(r_count[in_cls]) >= QUEUE_DEPTH) begin
                                n_res = make_err(ST_FULL);
                            end else begin
                                // Claim slot (non-emergency) and number, append at the tail.
                                if (in_cls != CLASS_EMERGENCY) begin
                                    n_slot_map[in_type_idx][free_slot] = 1'b1;
                                end
                                n_seq[in_cls]   = r_seq[in_cls] + SEQ_BITS'(1);
                                n_count[in_cls] = r_count[in_cls] + CNT_BITS'(1);
                                ram_we    = 1'b1;
                                ram_waddr = addr_of(in_cls, r_count[in_cls][POS_BITS-1:0]);
                                ram_wdata = book_ent;
                                n_res     = make_ok(in_cls, book_ent);
                            end
                        end
                        MODE_SERVE: begin
                            if (!serve_any) begin
                                n_res = make_err(ST_NOTHING);
                            end else begin
                                n_cls   = serve_cls;
                                n_idx   = '0;
                                n_serve = 1'b1;
                                n_state = S_SCAN_RD;
                            end
                        end
                        MODE_CANCEL: begin
                            n_cls   = in_cls;
                            n_idx   = '0;
                            n_serve = 1'b0;
                            n_state = S_SCAN_RD;
                        end
                        default: begin
                            n_res = make_err(ST_NOTHING);
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= r_count[r_cls]) begin
                    n_res   = make_err(ST_NOT_FOUND);
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                if (r_serve || ram_rdata.seq == r_cseq) begin
                    n_ent   = ram_rdata;
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                if (idx_inc >= r_count[r_cls]) begin
                    // Gap closed: drop the tail and release the slot on cancel.
                    n_count[r_cls] = r_count[r_cls] - CNT_BITS'(1);
                    if (!r_serve && r_cls != CLASS_EMERGENCY) begin
                        n_slot_map[ent_type_idx][r_ent.slot] = 1'b0;
                    end
                    n_res   = make_ok(r_cls, r_ent);
                    n_state = S_OUT;
                end else begin
                    ram_raddr = addr_of(r_cls, idx_inc[POS_BITS-1:0]);
                    n_state   = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = idx_inc;
                n_state   = S_SH_RD;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_status       = r_res.status;
    assign o_served_class = r_res.cls;
    assign o_patient_seq  = r_res.seq;
    assign o_out_type     = r_res.ctype;
    assign o_slot_index   = r_res.slot;
    assign o_slot_valid   = r_res.slot_valid;
    assign o_room         = r_res.room;

    // No class queue may grow past its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count[0]) <= QUEUE_DEPTH && 32'(r_count[1]) <= QUEUE_DEPTH &&
        32'(r_count[2]) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    // A shift write only targets a position inside the live queue.
    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SH_WR |-> idx_inc < r_count[r_cls])
        else $error("shift write past queue tail");

    // An ok result always reports a room one above its checkup type.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_room == o_out_type + 3'd1)
        else $error("room does not follow type");

    // A serve or cancel that ends in ok shortens its queue by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SH_RD && idx_inc >= r_count[r_cls] |=>
        r_count[r_cls] == $past(r_count[r_cls]) - CNT_BITS'(1))
        else $error("pop did not shorten queue");

endmodule
